FILE: rtl/core/vzd_pkg.sv
// Package with shared constants and types for the varint zigzag decoder.
package vzd_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_BYTES   = (VALUE_WIDTH + 6) / 7;
  localparam int COUNT_W     = $clog2(MAX_BYTES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = 3;

  localparam logic [ADDR_W-1:0] REG_SIGNED_MODE = ADDR_W'(0);

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERLONG  = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  localparam logic [1:0] KIND_CONT     = 2'd0;
  localparam logic [1:0] KIND_END      = 2'd1;
  localparam logic [1:0] KIND_OVERLONG = 2'd2;
  localparam logic [1:0] KIND_TRUNC    = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [3:0]  bytes_used;
  } out_item_t;

  typedef struct packed {
    logic [6:0]         payload;
    logic [COUNT_W-1:0] index;
    logic [1:0]         kind;
  } q_entry_t;

endpackage

FILE: rtl/core/vzd_front.sv
// Front end that accepts bytes, counts them per value and classifies each one.
module vzd_front
  import vzd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push,
  input  logic     q_full,
  output q_entry_t push_entry
);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_inc;
  logic [1:0]         kind;

  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;
  assign count_inc = count + COUNT_W'(1);

  always_comb begin
    priority if (!in_data.data_byte[7]) begin
      kind = KIND_END;
    end else if (count_inc == COUNT_W'(MAX_BYTES)) begin
      kind = KIND_OVERLONG;
    end else if (in_data.buffer_end) begin
      kind = KIND_TRUNC;
    end else begin
      kind = KIND_CONT;
    end
  end

  assign push_entry.payload = in_data.data_byte[6:0];
  assign push_entry.index   = count;
  assign push_entry.kind    = kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= (kind == KIND_CONT) ? count_inc : '0;
    end
  end

endmodule

FILE: rtl/core/vzd_queue.sv
// Short queue of classified bytes between the front end and the back end.
module vzd_queue
  import vzd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output q_entry_t head
);

  q_entry_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] fill;

  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      fill <= fill + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

FILE: rtl/core/vzd_back.sv
// Back end that gathers payload groups and drives the registered result.
module vzd_back
  import vzd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      signed_mode,
  input  logic      not_empty,
  input  q_entry_t  head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] acc_next;
  logic [VALUE_WIDTH-1:0] zz;
  logic [VALUE_WIDTH-1:0] result;
  logic [6:0]             shift;
  logic                   slot_free;
  out_item_t              res_next;

  assign slot_free = !out_valid || out_ready;
  assign pop       = not_empty && ((head.kind == KIND_CONT) || slot_free);
  assign shift     = 7'(head.index) * 7'd7;
  assign acc_next  = acc | VALUE_WIDTH'({{(VALUE_WIDTH - 7){1'b0}}, head.payload} << shift);
  assign zz        = (acc_next >> 1) ^ {VALUE_WIDTH{acc_next[0]}};
  assign result    = signed_mode ? zz : acc_next;

  always_comb begin
    res_next.value      = '0;
    res_next.bytes_used = 4'(head.index) + 4'd1;
    unique case (head.kind)
      KIND_END: begin
        res_next.value  = 64'(result);
        res_next.status = STATUS_OK;
      end
      KIND_OVERLONG: begin
        res_next.status = STATUS_OVERLONG;
      end
      KIND_TRUNC: begin
        res_next.status = STATUS_TRUNCATED;
      end
      default: begin
        res_next.status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        acc <= (head.kind == KIND_CONT) ? acc_next : '0;
      end
      if (pop && (head.kind != KIND_CONT)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.kind != KIND_CONT)) begin
      out_data <= res_next;
    end
  end

endmodule

FILE: rtl/core/varint_zigzag_decoder.sv
// Top level of the LEB128 varint decoder with optional zigzag decoding.
// The decoder takes one encoded byte per cycle while the queue has room: a front end counts
// and classifies each byte, a two-entry queue carries it to a back end that shifts the
// payload into the accumulator and loads the output register. A result goes through the queue
// and then the output register, held back while an earlier result waits, and input keeps
// flowing while a result waits on out_ready until the queue fills. Register signed_mode lies
// at byte address 0 of the configuration port and is sampled when a value ends.
module varint_zigzag_decoder
  import vzd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic     signed_mode;
  logic     push;
  logic     q_full;
  logic     pop;
  logic     not_empty;
  q_entry_t push_entry;
  q_entry_t head;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SIGNED_MODE) ? {31'b0, signed_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_SIGNED_MODE)) begin
      signed_mode <= pwdata[0];
    end
  end

  vzd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .q_full     (q_full),
    .push_entry (push_entry)
  );

  vzd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  vzd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .signed_mode (signed_mode),
    .not_empty   (not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

FILE: rtl/core/vzd_checker.sv
// Port-level checker for the varint zigzag decoder and its bind statement.
module vzd_checker
  import vzd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed while stalled.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == STATUS_OK) || (out_data.status == STATUS_OVERLONG) ||
                  (out_data.status == STATUS_TRUNCATED))
    else $error("Unknown status code.");

  a_error_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != STATUS_OK) |-> out_data.value == 64'd0)
    else $error("Error result carries a nonzero value.");

  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.bytes_used >= 4'd1) && (out_data.bytes_used <= 4'(MAX_BYTES)))
    else $error("Byte count out of range.");

  a_overlong_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == STATUS_OVERLONG) |-> out_data.bytes_used == 4'(MAX_BYTES))
    else $error("Overlong result with wrong byte count.");

endmodule

bind varint_zigzag_decoder vzd_checker u_vzd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/sv/varint_zigzag_decoder_tb.sv
// Testbench for the varint zigzag decoder: byte streams are checked against a predictor.
module varint_zigzag_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vzd_pkg::*;

  localparam logic [63:0] VALUE_MASK = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 1);
  localparam int STALL_LIMIT = 5000;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_BYTES = 242;
  localparam bit PHASE_MODES [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

  class varint_scoreboard;
    logic [63:0] acc;
    int nbytes;
    bit zigzag;
    out_item_t expected_results[$];
    int failures;

    function new();
      acc = '0;
      nbytes = 0;
      zigzag = 1'b0;
      failures = 0;
    endfunction

    function void set_mode(bit m);
      zigzag = m;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_byte(in_item_t item);
      int cnt;
      out_item_t r;
      cnt = (nbytes >= MAX_BYTES) ? 0 : nbytes;
      acc = (acc | (64'(item.data_byte[6:0]) << ((cnt * 7) % 64))) & VALUE_MASK;
      cnt++;
      r.value = '0;
      r.bytes_used = 4'(cnt);
      if (!item.data_byte[7]) begin
        r.value = zigzag ? (((acc >> 1) ^ {64{acc[0]}}) & VALUE_MASK) : acc;
        r.status = STATUS_OK;
      end else if (cnt >= MAX_BYTES) begin
        r.status = STATUS_OVERLONG;
      end else if (item.buffer_end) begin
        r.status = STATUS_TRUNCATED;
      end else begin
        nbytes = cnt;
        return;
      end
      expected_results.push_back(r);
      acc = '0;
      nbytes = 0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: value %h status %0d bytes_used %0d",
               got.value, got.status, got.bytes_used);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %h, actual %h", want.value, got.value);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.bytes_used !== want.bytes_used) begin
        $error("bytes_used: expected %0d, actual %0d", want.bytes_used, got.bytes_used);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  varint_scoreboard sb = new();
  int send_idle_pct = 37;
  int ready_idle_pct = 37;
  int bytes_sent = 0;
  int stall_cycles = 0;

  varint_zigzag_decoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= ready_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, buffer_end: last};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_SIGNED_MODE;
    pwdata <= 32'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_mode(m);
  endtask

  function automatic logic [6:0] pick_payload();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return 7'h7f;
    if (roll < 35) return 7'h00;
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic send_random_value();
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      if ($urandom_range(0, 19) == 0) n = MAX_BYTES;
      else if ($urandom_range(0, 5) == 0) n = $urandom_range(4, MAX_BYTES);
      else n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        send_byte({i < n - 1, pick_payload()}, (i == n - 1) && ($urandom_range(0, 7) == 0));
      end
    end else if (roll < 82) begin
      n = $urandom_range(1, MAX_BYTES - 1);
      for (int i = 0; i < n; i++) send_byte({1'b1, pick_payload()}, i == n - 1);
    end else if (roll < 90) begin
      for (int i = 0; i < MAX_BYTES; i++) begin
        send_byte({1'b1, pick_payload()}, (i == MAX_BYTES - 1) && $urandom_range(0, 1));
      end
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end
    if ($urandom_range(0, 199) == 0) drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h80, 1'b1);
    for (int i = 0; i < MAX_BYTES - 1; i++) send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    for (int i = 0; i < MAX_BYTES - 1; i++) send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_mode(PHASE_MODES[p]);
      send_idle_pct = (p == 2) ? 0 : 37;
      ready_idle_pct = (p == 2) ? 0 : 37;
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) send_random_value();
      if (p < NUM_PHASES - 1) send_byte({1'b1, pick_payload()}, 1'b0);
    end

    settle();
    if (sb.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/vzd_pkg.sv
rtl/core/vzd_front.sv
rtl/core/vzd_queue.sv
rtl/core/vzd_back.sv
rtl/core/varint_zigzag_decoder.sv
rtl/core/vzd_checker.sv
tb/sv/varint_zigzag_decoder_tb.sv
